/* sv/wsd_pkg.sv */
package wsd_pkg;

  typedef enum logic [5:0] {
    PH_BYTE0 = 6'b000001,
    PH_BYTE1 = 6'b000010,
    PH_LEN16 = 6'b000100,
    PH_LEN64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_e;

  localparam logic [1:0] KIND_ABSORB  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [1:0] CLASS_DATA    = 2'd0;
  localparam logic [1:0] CLASS_CONTROL = 2'd1;
  localparam logic [1:0] CLASS_CONT    = 2'd2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [3:0] LEN16_BYTES = 4'd2;
  localparam logic [3:0] LEN64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [1:0]  frame_class;
    logic        masked;
    logic [63:0] payload_len;
    logic [7:0]  payload_byte;
    logic        last;
  } result_t;

  function automatic logic [1:0] class_of(input logic [3:0] op);
    logic [1:0] c;
    c = CLASS_DATA;
    if (op == OP_CONT) begin
      c = CLASS_CONT;
    end else if (op == OP_CLOSE || op == OP_PING || op == OP_PONG) begin
      c = CLASS_CONTROL;
    end
    return c;
  endfunction

  function automatic logic is_known_op(input logic [3:0] op);
    return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
  endfunction

endpackage

/* sv/websocket_frame_deframer_unit.sv */
// WebSocket frame deframer: parses a received byte stream into frames and
// unmasks the payload.
// Input channel: one stream byte per beat on data_byte_i (in_valid_i /
// in_ready_o). Output channel: exactly one result beat per input byte
// (out_valid_o / out_ready_i) carrying kind_o (absorbed header byte, header
// complete, payload byte, error), the current frame's fin, opcode, class,
// mask flag and length, the unmasked payload byte and the last flag.
// Pipeline: an accepted byte is held in the input register, parsed, and its
// result captured in the result register (one input register, one result
// register), from which its result beat is taken.
// Throughput: one byte per cycle while out_ready_i stays high; the parse logic
// between the input register and the result register is combinational.
// Stall: when out_ready_i is low the result holds, and the input register
// still takes one more byte; in_ready_o drops only when both stages are full.
// Reset: rst_ni clears both stages and returns the parser to expecting the
// first header byte of a new frame. An error result also returns the parser
// to expecting the first header byte.
module websocket_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        fin_o,
  output logic [3:0]  opcode_o,
  output logic [1:0]  frame_class_o,
  output logic        masked_o,
  output logic [63:0] payload_len_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_o
);
  import wsd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    res;
  logic       step;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign fin_o          = out_q.fin;
  assign opcode_o       = out_q.opcode;
  assign frame_class_o  = out_q.frame_class;
  assign masked_o       = out_q.masked;
  assign payload_len_o  = out_q.payload_len;
  assign payload_byte_o = out_q.payload_byte;
  assign last_o         = out_q.last;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_ERROR |->
      out_q.frame_class == CLASS_DATA && out_q.payload_len == 64'd0 && !out_q.last)
    else $error("error result carries frame fields");

  a_absorb_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_ABSORB |-> !out_q.last && out_q.payload_byte == 8'd0)
    else $error("absorbed header byte flagged last or with data");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a waiting byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("stalled result dropped");

  a_step_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

endmodule

/* sv/wsd_parser.sv */
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output wsd_pkg::result_t res_o
);
  import wsd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic [63:0] len_q, len_d;
  logic [31:0] key_q, key_d;
  logic [63:0] pos_q, pos_d;

  logic [3:0]  cnt_inc;
  logic [3:0]  need;
  logic        hdr_done;
  logic        err;
  logic [1:0]  kind;
  logic [7:0]  pbyte;
  logic        last;
  logic [7:0]  key_byte;

  assign cnt_inc = cnt_q + 4'd1;
  assign need    = (phase_q == PH_LEN16) ? LEN16_BYTES : LEN64_BYTES;

  always_comb begin
    case (pos_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    op_d     = op_q;
    masked_d = masked_q;
    len_d    = len_q;
    key_d    = key_q;
    pos_d    = pos_q;
    hdr_done = 1'b0;
    err      = 1'b0;
    kind     = KIND_ABSORB;
    pbyte    = 8'd0;
    last     = 1'b0;

    case (phase_q)
      PH_BYTE1: begin
        masked_d = byte_i[7];
        cnt_d    = 4'd0;
        len_d    = 64'd0;
        if (byte_i[6:0] < LEN_EXT16) begin
          len_d = {57'd0, byte_i[6:0]};
          if (byte_i[7]) begin
            phase_d = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end else if (byte_i[6:0] == LEN_EXT16) begin
          phase_d = PH_LEN16;
        end else begin
          phase_d = PH_LEN64;
        end
      end
      PH_LEN16, PH_LEN64: begin
        len_d = {len_q[55:0], byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc >= need) begin
          cnt_d = 4'd0;
          if (masked_q) begin
            phase_d = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc >= KEY_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        pbyte = masked_q ? (byte_i ^ key_byte) : byte_i;
        kind  = KIND_PAYLOAD;
        pos_d = pos_q + 64'd1;
        if (pos_d >= len_q) begin
          last    = 1'b1;
          phase_d = PH_BYTE0;
        end
      end
      default: begin
        cnt_d    = 4'd0;
        fin_d    = 1'b0;
        op_d     = 4'd0;
        masked_d = 1'b0;
        len_d    = 64'd0;
        key_d    = 32'd0;
        pos_d    = 64'd0;
        if ((byte_i[6:4] != 3'd0) || !is_known_op(byte_i[3:0])) begin
          err     = 1'b1;
          phase_d = PH_BYTE0;
        end else begin
          fin_d   = byte_i[7];
          op_d    = byte_i[3:0];
          phase_d = PH_BYTE1;
        end
      end
    endcase

    if (hdr_done) begin
      pos_d = 64'd0;
      cnt_d = 4'd0;
      kind  = KIND_HEADER;
      if (len_d == 64'd0) begin
        last    = 1'b1;
        phase_d = PH_BYTE0;
      end else begin
        phase_d = PH_DATA;
      end
    end
  end

  always_comb begin
    if (err) begin
      res_o              = '0;
      res_o.kind         = KIND_ERROR;
      res_o.fin          = byte_i[7];
      res_o.opcode       = byte_i[3:0];
    end else begin
      res_o.kind         = kind;
      res_o.fin          = fin_d;
      res_o.opcode       = op_d;
      res_o.frame_class  = class_of(op_d);
      res_o.masked       = masked_d;
      res_o.payload_len  = len_d;
      res_o.payload_byte = pbyte;
      res_o.last         = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_BYTE0;
      cnt_q    <= 4'd0;
      fin_q    <= 1'b0;
      op_q     <= 4'd0;
      masked_q <= 1'b0;
      len_q    <= 64'd0;
      key_q    <= 32'd0;
      pos_q    <= 64'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      key_q    <= key_d;
      pos_q    <= pos_d;
    end
  end

endmodule
